/* hdl/rad_pkg.sv */
// Shared types and constants for the room allocator with delay.
`default_nettype none

package rad_pkg;

    // Default for the number of resource slots held in the tables.
    localparam int MAX_RES_DEF = 64;

    // Fixed field widths.
    localparam int REQ_W     = 32;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 7;
    localparam int RES_IDX_W = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Width used to clamp the configured count against the slot count (up to 511).
    localparam int NCALC_W = 9;

    // Register index, taken from paddr[2].
    localparam logic REG_RESOURCES_IN_USE = 1'b0;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_CNT_RD,
        ST_COMMIT
    } rad_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic cnt_rd;
        logic commit;
    } rad_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_blocked;
    } rad_status_t;

endpackage

`default_nettype wire

/* hdl/rad_ctrl.sv */
// Controller state machine that sequences the scan, count update and commit.
`default_nettype none

module rad_ctrl
    import rad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire rad_status_t status,
    output rad_cmd_t         cmd
);

    rad_state_t state_reg;
    rad_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                // The last free time read is evaluated in this cycle.
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rad_dpath.sv */
// Datapath: free time and use count memories, scan compare, update and result register.
`default_nettype none

module rad_dpath
    import rad_pkg::*;
#(
    parameter int MAX_RESOURCES = MAX_RES_DEF,
    parameter int IDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rad_cmd_t           cmd,
    output rad_status_t             status,
    input  wire logic [CFG_W-1:0]   resources_in_use,
    input  wire logic [REQ_W-1:0]   request_start,
    input  wire logic [REQ_W-1:0]   request_end,
    input  wire logic               start_of_job,
    input  wire logic               res_stall,
    output logic                    res_valid,
    output logic [IDX_W-1:0]        assigned_idx,
    output logic                    was_delayed,
    output logic [TIME_W-1:0]       scheduled_end,
    output logic [IDX_W-1:0]        best_idx
);

    localparam logic [NCALC_W-1:0] MAX_N = NCALC_W'(MAX_RESOURCES);

    // Memories; an entry whose valid bit is clear reads as zero.
    logic [TIME_W-1:0]  time_mem [MAX_RESOURCES];
    logic [COUNT_W-1:0] cnt_mem  [MAX_RESOURCES];

    logic [MAX_RESOURCES-1:0] valid_reg, valid_next;

    logic [REQ_W-1:0]   start_reg, start_next;
    logic [REQ_W-1:0]   end_reg, end_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               eval_en_reg, eval_en_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic               time_vld_reg, time_vld_next;
    logic [TIME_W-1:0]  time_rd_reg;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   first_idx_reg, first_idx_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [TIME_W-1:0]  min_time_reg, min_time_next;
    logic               cnt_vld_reg, cnt_vld_next;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [COUNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_delayed_reg, out_delayed_next;
    logic [TIME_W-1:0]  out_end_reg, out_end_next;
    logic [IDX_W-1:0]   out_best_reg, out_best_next;

    logic [NCALC_W-1:0] cfg_ext;
    logic [NCALC_W-1:0] active_n;
    logic [NCALC_W-1:0] last_n;
    logic [IDX_W-1:0]   last_idx;
    logic [TIME_W-1:0]  time_eff;
    logic [TIME_W-1:0]  start_ext;
    logic [REQ_W-1:0]   dur;
    logic [IDX_W-1:0]   pick;
    logic [TIME_W:0]    time_sum;
    logic [TIME_W-1:0]  new_time;
    logic [COUNT_W-1:0] cnt_eff;
    logic [COUNT_W-1:0] cnt_new;
    logic               better;

    // Active count, clamped to one through the slot count.
    always_comb
    begin
        cfg_ext = NCALC_W'(resources_in_use);
        if (cfg_ext == '0)
        begin
            active_n = NCALC_W'(1);
        end
        else if (cfg_ext > MAX_N)
        begin
            active_n = MAX_N;
        end
        else
        begin
            active_n = cfg_ext;
        end
        last_n   = active_n - NCALC_W'(1);
        last_idx = last_n[IDX_W-1:0];
    end

    // Arithmetic on the scan result and the use count.
    always_comb
    begin
        time_eff  = time_vld_reg ? time_rd_reg : '0;
        start_ext = TIME_W'(start_reg);
        dur       = (end_reg > start_reg) ? (end_reg - start_reg) : '0;
        pick      = found_reg ? first_idx_reg : min_idx_reg;
        time_sum  = {1'b0, min_time_reg} + (TIME_W + 1)'(dur);
        if (found_reg)
        begin
            new_time = TIME_W'(end_reg);
        end
        else if (time_sum[TIME_W])
        begin
            new_time = '1;
        end
        else
        begin
            new_time = time_sum[TIME_W-1:0];
        end
        cnt_eff = cnt_vld_reg ? cnt_rd_reg : '0;
        cnt_new = (cnt_eff == '1) ? cnt_eff : (cnt_eff + COUNT_W'(1));
        better  = (cnt_new > best_cnt_reg) ||
                  ((cnt_new == best_cnt_reg) && (pick < best_idx_reg));
    end

    // Next values of the control and scan registers.
    always_comb
    begin
        valid_next       = valid_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        scan_idx_next    = scan_idx_reg;
        eval_en_next     = cmd.scan_rd;
        eval_idx_next    = scan_idx_reg;
        time_vld_next    = time_vld_reg;
        found_next       = found_reg;
        first_idx_next   = first_idx_reg;
        min_idx_next     = min_idx_reg;
        min_time_next    = min_time_reg;
        cnt_vld_next     = cnt_vld_reg;
        best_cnt_next    = best_cnt_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg && res_stall;
        out_idx_next     = out_idx_reg;
        out_delayed_next = out_delayed_reg;
        out_end_next     = out_end_reg;
        out_best_next    = out_best_reg;

        // Take a new item and clear the tables on a start of job.
        if (cmd.load)
        begin
            start_next     = request_start;
            end_next       = request_end;
            scan_idx_next  = '0;
            found_next     = 1'b0;
            first_idx_next = '0;
            min_idx_next   = '0;
            min_time_next  = '1;
            if (start_of_job)
            begin
                valid_next    = '0;
                best_cnt_next = '0;
                best_idx_next = '0;
            end
        end

        // Issue one free time read per cycle.
        if (cmd.scan_rd)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            time_vld_next = valid_reg[scan_idx_reg];
        end

        // Evaluate the free time read in the previous cycle.
        if (eval_en_reg)
        begin
            if (!found_reg && (time_eff <= start_ext))
            begin
                found_next     = 1'b1;
                first_idx_next = eval_idx_reg;
            end
            if (time_eff < min_time_reg)
            begin
                min_time_next = time_eff;
                min_idx_next  = eval_idx_reg;
            end
        end

        if (cmd.cnt_rd)
        begin
            cnt_vld_next = valid_reg[pick];
        end

        // Commit the tables and load the result register, including the
        // most-used index, so a waiting result stays put while the next item runs.
        if (cmd.commit)
        begin
            valid_next[pick] = 1'b1;
            out_best_next    = best_idx_reg;
            if (better)
            begin
                best_cnt_next = cnt_new;
                best_idx_next = pick;
                out_best_next = pick;
            end
            out_valid_next   = 1'b1;
            out_idx_next     = pick;
            out_delayed_next = !found_reg;
            out_end_next     = new_time;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            eval_en_reg   <= 1'b0;
            best_cnt_reg  <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            eval_en_reg   <= eval_en_next;
            best_cnt_reg  <= best_cnt_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        start_reg       <= start_next;
        end_reg         <= end_next;
        scan_idx_reg    <= scan_idx_next;
        eval_idx_reg    <= eval_idx_next;
        time_vld_reg    <= time_vld_next;
        found_reg       <= found_next;
        first_idx_reg   <= first_idx_next;
        min_idx_reg     <= min_idx_next;
        min_time_reg    <= min_time_next;
        cnt_vld_reg     <= cnt_vld_next;
        out_idx_reg     <= out_idx_next;
        out_delayed_reg <= out_delayed_next;
        out_end_reg     <= out_end_next;
        out_best_reg    <= out_best_next;
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            time_mem[pick] <= new_time;
            cnt_mem[pick]  <= cnt_new;
        end
        if (cmd.scan_rd)
        begin
            time_rd_reg <= time_mem[scan_idx_reg];
        end
        if (cmd.cnt_rd)
        begin
            cnt_rd_reg <= cnt_mem[pick];
        end
    end

    // Status and result outputs.
    assign status        = '{scan_last:   (scan_idx_reg == last_idx),
                             out_blocked: (out_valid_reg && res_stall)};
    assign res_valid     = out_valid_reg;
    assign assigned_idx  = out_idx_reg;
    assign was_delayed   = out_delayed_reg;
    assign scheduled_end = out_end_reg;
    assign best_idx      = out_best_reg;

endmodule

`default_nettype wire

/* hdl/room_allocator_with_delay.sv */
// Top level of the room allocator with delay: configuration register and block wiring.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  request_start, request_end, start_of_job
// res       out        res_valid/res_stall  assigned_resource, was_delayed,
//                                           scheduled_end, most_used_resource
// cfg       in         APB psel/penable     resources_in_use at byte address 0
//
// An item is taken, then its n free times, n being the active resource count, are read in
// turn through the single memory read port; the item is then evaluated, its use count read
// and the tables committed.
// Reset and a start of job clear the tables at once through per-entry valid bits.
// A result waits in the output register under res_stall; the next item is taken
// meanwhile and holds only at its commit until that register frees.
`default_nettype none

module room_allocator_with_delay
    import rad_pkg::*;
#(
    parameter int MAX_RESOURCES = MAX_RES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic [REQ_W-1:0]      request_start,
    input  wire logic [REQ_W-1:0]      request_end,
    input  wire logic                  start_of_job,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic [RES_IDX_W-1:0]       assigned_resource,
    output logic                       was_delayed,
    output logic [TIME_W-1:0]          scheduled_end,
    output logic [RES_IDX_W-1:0]       most_used_resource
);

    localparam int IDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    logic [CFG_W-1:0] res_in_use_reg, res_in_use_next;
    logic             cfg_wr;

    rad_cmd_t    cmd;
    rad_status_t status;

    logic [IDX_W-1:0]           assigned_idx;
    logic [IDX_W-1:0]           best_idx;
    logic [IDX_W+RES_IDX_W-1:0] assigned_ext;
    logic [IDX_W+RES_IDX_W-1:0] best_ext;

    // Configuration register write and read.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == REG_RESOURCES_IN_USE);

    always_comb
    begin
        res_in_use_next = res_in_use_reg;
        if (cfg_wr)
        begin
            res_in_use_next = pwdata[CFG_W-1:0];
        end
        if (paddr[2] == REG_RESOURCES_IN_USE)
        begin
            prdata = APB_DW'(res_in_use_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_in_use_reg <= CFG_W'(1);
        end
        else
        begin
            res_in_use_reg <= res_in_use_next;
        end
    end

    // Controller.
    rad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    rad_dpath #(
        .MAX_RESOURCES (MAX_RESOURCES),
        .IDX_W         (IDX_W)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .resources_in_use (res_in_use_reg),
        .request_start    (request_start),
        .request_end      (request_end),
        .start_of_job     (start_of_job),
        .res_stall        (res_stall),
        .res_valid        (res_valid),
        .assigned_idx     (assigned_idx),
        .was_delayed      (was_delayed),
        .scheduled_end    (scheduled_end),
        .best_idx         (best_idx)
    );

    // Indexes are reported in the six-bit result fields.
    assign assigned_ext       = {{RES_IDX_W{1'b0}}, assigned_idx};
    assign best_ext           = {{RES_IDX_W{1'b0}}, best_idx};
    assign assigned_resource  = assigned_ext[RES_IDX_W-1:0];
    assign most_used_resource = best_ext[RES_IDX_W-1:0];

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the room allocator with delay: directed, random and stress tests.
module tb_top;
    import rad_pkg::*;

    localparam int ROOMS = MAX_RES_DEF;
    localparam logic [TIME_W-1:0]  TIME_SAT  = '1;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [APB_AW-1:0]  ADDR_ROOM_COUNT = {REG_RESOURCES_IN_USE, 2'b00};

    // One expected result of a booking.
    typedef struct packed {
        logic [RES_IDX_W-1:0] room;
        logic                 delayed;
        logic [TIME_W-1:0]    end_time;
        logic [RES_IDX_W-1:0] busiest;
    } booking_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  req_valid     = 1'b0;
    logic                  req_stall;
    logic [REQ_W-1:0]      request_start = '0;
    logic [REQ_W-1:0]      request_end   = '0;
    logic                  start_of_job  = 1'b0;
    logic                  res_valid;
    logic                  res_stall     = 1'b0;
    logic [RES_IDX_W-1:0]  assigned_resource;
    logic                  was_delayed;
    logic [TIME_W-1:0]     scheduled_end;
    logic [RES_IDX_W-1:0]  most_used_resource;

    // Scheduler state as the testbench expects it to be.
    logic [TIME_W-1:0]     room_free_at [ROOMS];
    logic [COUNT_W-1:0]    room_uses [ROOMS];
    logic [COUNT_W-1:0]    top_uses;
    logic [RES_IDX_W-1:0]  top_room;
    logic [CFG_W-1:0]      room_count_reg = 7'd1;

    booking_t pending_bookings [$];
    int       mismatches       = 0;
    int       bookings_sent    = 0;
    int       bookings_checked = 0;
    int       settings_used    = 0;
    bit       idle_on          = 1'b0;
    int       hold_off_cycles  = 0;

    room_allocator_with_delay #(
        .MAX_RESOURCES(ROOMS)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .request_start      (request_start),
        .request_end        (request_end),
        .start_of_job       (start_of_job),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .assigned_resource  (assigned_resource),
        .was_delayed        (was_delayed),
        .scheduled_end      (scheduled_end),
        .most_used_resource (most_used_resource)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Global timeout.
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Clear both tables and the running maximum, as at reset or a start of job.
    function automatic void clear_rooms();
        for (int i = 0; i < ROOMS; i++)
        begin
            room_free_at[i] = '0;
            room_uses[i]    = '0;
        end
        top_uses = '0;
        top_room = '0;
    endfunction

    // Number of rooms that take part, after clamping the register value.
    function automatic int active_rooms();
        int n;
        n = room_count_reg;
        if (n == 0)
            n = 1;
        if (n > ROOMS)
            n = ROOMS;
        return n;
    endfunction

    // Assign one booking and update the expected tables.
    function automatic booking_t allocate_room(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                                               input logic job);
        booking_t             b;
        logic [TIME_W-1:0]    dur;
        int                   n;
        int                   pick;
        bit                   found;
        if (job)
            clear_rooms();
        n     = active_rooms();
        dur   = (e > s) ? TIME_W'(e - s) : '0;
        found = 1'b0;
        pick  = 0;
        // First room that is already free at the start time.
        for (int i = 0; i < n && !found; i++)
        begin
            if (room_free_at[i] <= TIME_W'(s))
            begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (found)
            room_free_at[pick] = TIME_W'(e);
        else
        begin
            // No room free: take the one that frees earliest and push it out.
            for (int i = 1; i < n; i++)
            begin
                if (room_free_at[i] < room_free_at[pick])
                    pick = i;
            end
            if (room_free_at[pick] > TIME_SAT - dur)
                room_free_at[pick] = TIME_SAT;
            else
                room_free_at[pick] = room_free_at[pick] + dur;
        end
        if (room_uses[pick] != COUNT_SAT)
            room_uses[pick] = room_uses[pick] + 1'b1;
        if (room_uses[pick] > top_uses ||
            (room_uses[pick] == top_uses && RES_IDX_W'(pick) < top_room))
        begin
            top_uses = room_uses[pick];
            top_room = RES_IDX_W'(pick);
        end
        b.room     = RES_IDX_W'(pick);
        b.delayed  = !found;
        b.end_time = room_free_at[pick];
        b.busiest  = top_room;
        return b;
    endfunction

    initial
    begin
        clear_rooms();
    end

    // Receiver stall: long hold-offs on request, random bursts while idling is on.
    initial
    begin : drive_result_stall
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                burst           = hold_off_cycles;
                hold_off_cycles = 0;
                res_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Report one field that differs from its expectation.
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 20)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Compare every result item with the oldest pending booking.
    always @(posedge clk)
    begin : check_bookings
        booking_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            bookings_checked++;
            if (pending_bookings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: result with no booking pending, expected none, actual room %0d",
                             $time, assigned_resource);
            end
            else
            begin
                want = pending_bookings.pop_front();
                check_field("assigned_resource", want.room, assigned_resource);
                check_field("was_delayed", want.delayed, was_delayed);
                check_field("scheduled_end", want.end_time, scheduled_end);
                check_field("most_used_resource", want.busiest, most_used_resource);
            end
        end
    end

    // Offer one booking item and record its expected result once accepted.
    task automatic send_request(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                                input logic job);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid     <= 1'b1;
        request_start <= s;
        request_end   <= e;
        start_of_job  <= job;
        do
            @(posedge clk);
        while (req_stall);
        pending_bookings.push_back(allocate_room(s, e, job));
        bookings_sent++;
    endtask

    // Stop offering items and wait until every expected result has come.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_bookings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the room count register, then read it back.
    task automatic write_room_count(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROOM_COUNT;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        room_count_reg = value;
        settings_used++;
        // Back-to-back read transfer.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("resources_in_use readback", value, prdata[CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Free and busy rooms, delays, zero and negative durations, extreme times.
    task automatic test_directed_bookings();
        write_room_count(7'd3);
        send_request(32'd0, 32'd10, 1'b1);
        send_request(32'd0, 32'd5, 1'b0);
        send_request(32'd0, 32'd7, 1'b0);
        send_request(32'd2, 32'd4, 1'b0);
        send_request(32'd7, 32'd8, 1'b0);
        send_request(32'd8, 32'd8, 1'b0);
        send_request(32'd9, 32'd3, 1'b0);
        send_request(32'd9, 32'd100, 1'b0);
        send_request(32'd9, 32'd100, 1'b0);
        // All rooms busy with no duration left to add.
        send_request(32'd9, 32'd9, 1'b0);
        send_request(32'd9, 32'd2, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFF, 32'd0, 1'b0);
        // New job with full-range durations; the delayed one crosses 32 bits.
        send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        wait_for_results();
    endtask

    // Rooms dropped from the active set keep their counts for the busiest-room output.
    task automatic test_inactive_rooms_keep_counts();
        write_room_count(7'd3);
        send_request(32'd0, 32'd100, 1'b1);
        send_request(32'd0, 32'd100, 1'b0);
        send_request(32'd0, 32'd1, 1'b0);
        send_request(32'd1, 32'd2, 1'b0);
        send_request(32'd2, 32'd3, 1'b0);
        wait_for_results();
        write_room_count(7'd1);
        send_request(32'd200, 32'd300, 1'b0);
        send_request(32'd300, 32'd400, 1'b0);
        wait_for_results();
    endtask

    // Long receiver hold-off while items keep coming, so the input stalls.
    task automatic test_output_hold_off();
        write_room_count(7'd2);
        idle_on         = 1'b0;
        hold_off_cycles = 300;
        send_request(32'd0, 32'd50, 1'b1);
        for (int k = 1; k < 12; k++)
            send_request(REQ_W'(k * 4), REQ_W'(k * 4 + 30), 1'b0);
        wait_for_results();
    endtask

    // Random jobs of ordered requests over a range of room counts.
    task automatic test_random_bookings();
        logic [CFG_W-1:0] counts [10] = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127,
                                         7'd3, 7'd8, 7'd65, 7'd5, 7'd16};
        logic [REQ_W-1:0] s;
        logic [REQ_W-1:0] e;
        logic [REQ_W:0]   nxt;
        logic             job;
        int               left_in_job;
        s = '0;
        counts[8] = CFG_W'($urandom_range(1, ROOMS));
        for (int p = 0; p < 10; p++)
        begin
            wait_for_results();
            write_room_count(counts[p]);
            idle_on     = (p % 5) != 4;
            left_in_job = 0;
            for (int k = 0; k < 45; k++)
            begin
                job = 1'b0;
                if (left_in_job == 0)
                begin
                    // Open a new job, usually with the clearing flag.
                    left_in_job = $urandom_range(1, 40);
                    job         = ($urandom_range(0, 7) != 0);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: s = $urandom_range(0, 1000);
                        9:             s = 32'hFFFF_FC00 | $urandom_range(0, 1023);
                        default:       s = $urandom();
                    endcase
                end
                else if ($urandom_range(0, 49) == 0)
                    s = $urandom();
                else
                begin
                    // Non-decreasing start, holding at the top of the range.
                    if ($urandom_range(0, 19) == 0)
                        nxt = {1'b0, s} + $urandom_range(0, 5000);
                    else
                        nxt = {1'b0, s} + $urandom_range(0, 12);
                    s = nxt[REQ_W] ? '1 : nxt[REQ_W-1:0];
                end
                left_in_job--;
                case ($urandom_range(0, 19))
                    0:       e = s;
                    1:       e = s - $urandom_range(1, 100);
                    2:       e = '1;
                    3:       e = $urandom();
                    default: e = s + $urandom_range(1, 8 * active_rooms() + 20);
                endcase
                send_request(s, e, job);
            end
        end
        wait_for_results();
    endtask

    // One room, a chain of maximal delays that pushes its free time far past 32 bits.
    task automatic test_long_delay_chain();
        write_room_count(7'd1);
        idle_on = 1'b0;
        send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
        // Each delayed booking adds 2^32 - 1 to the free time.
        repeat (18) send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(32'd1, 32'd2, 1'b0);
        wait_for_results();
    endtask

    // Reset, then the tests in turn.
    initial
    begin : run_tests
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_bookings();
        test_inactive_rooms_keep_counts();
        test_output_hold_off();
        test_random_bookings();
        test_long_delay_chain();
        wait_for_results();
        repeat (80) @(posedge clk);
        $display("Checked %0d results for %0d bookings over %0d room-count writes,",
                 bookings_checked, bookings_sent, settings_used);
        $display("with random idling, a long output hold-off and free times beyond 32 bits.");
        if (mismatches == 0 && pending_bookings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
